FILE: rtl/core/modular_inverse_ext_euclid_assert.svh
// Assertion macros for the modular inverse block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH

// same-cycle implication
`define MIE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("modinv: same-cycle check failed");

// next-cycle implication
`define MIE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("modinv: next-cycle check failed");

`endif

FILE: rtl/core/modinv_pkg.sv
// Shared constants and types for the modular inverse block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package modinv_pkg;

    localparam int FIELD_W     = 31;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;
    localparam int CNT_W       = $clog2(FIELD_W);

    localparam logic [FIELD_W-1:0] MODULUS_RST = FIELD_W'(2);

    typedef logic [1:0] t_state;

    localparam t_state S_IDLE = 2'd0;
    localparam t_state S_CHK  = 2'd1;
    localparam t_state S_DIV  = 2'd2;
    localparam t_state S_UPD  = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/core/modular_inverse_ext_euclid.sv
// Modular inverse by the extended Euclidean algorithm, one shared bit-serial unit.
// Depends on modinv_pkg and modular_inverse_ext_euclid_assert.svh.
//
//  port group     dir   width  contents
//  i_s_axis_*     in    32     value[30:0]
//  o_m_axis_*     out   64     inverse[30:0], divisor[61:31]
//  i_cfg_wr_*     in    31     modulus
//
// Each item runs Euclid rounds until the remainder is zero; an out of range
// value (at or above the modulus) finishes after the check alone. Each round
// is 31 restoring-division steps on the shared subtract/compare unit, with the
// quotient times coefficient built by shift-add in the same steps, plus one
// update step and one check step.
// Reset is synchronous, active low; modulus resets to 2.
// Input is refused while an item is in flight; a result held at the output
// stalls the sequencer only when the next result is ready to load.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_inverse_ext_euclid_assert.svh"

module modular_inverse_ext_euclid #(
    parameter int WIDTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config: modulus
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [modinv_pkg::FIELD_W-1:0]     i_cfg_wr_data,
    // tdata: [30:0] value, [31] zero pad
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [modinv_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tdata: [30:0] inverse, [61:31] divisor, [63:62] zero pad
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [modinv_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);
    import modinv_pkg::*;

    localparam int CW = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;

    logic [FIELD_W-1:0] r_modulus;
    t_state             r_state, n_state;
    logic [FIELD_W-1:0] r_mod;
    logic [FIELD_W-1:0] r_rp, r_rc, r_rem, r_dvd;
    logic [WIDTH-1:0]   r_c_prev, r_c_cur, r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out_inv, r_out_div;

    logic [FIELD_W-1:0] w_value;
    logic               w_in_xfer;
    logic               w_out_free;
    logic [FIELD_W:0]   w_trial;
    logic               w_ge;
    logic signed [CW-1:0] w_coef_ext;
    logic [FIELD_W-1:0] w_lift;
    logic [FIELD_W-1:0] w_inv;
    logic               w_finish;

    assign w_value         = i_s_axis_tdata[FIELD_W-1:0];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // one restoring-division step
    assign w_trial = {r_rem, r_dvd[FIELD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_rc});

    // lift the final coefficient into range (wraps at the field width)
    assign w_coef_ext = CW'($signed(r_c_prev));
    assign w_lift     = r_mod + w_coef_ext[FIELD_W-1:0];
    assign w_inv      = (r_c_prev[WIDTH-1] || (r_c_prev == '0)) ? w_lift
                                                                : w_coef_ext[FIELD_W-1:0];
    assign w_finish   = (r_state == S_CHK) && (r_rc == '0) && w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) n_state = S_CHK;
            end
            S_CHK: begin
                if (r_rc != '0) n_state = S_DIV;
                else if (w_out_free) n_state = S_IDLE;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_CHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= MODULUS_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_modulus <= i_cfg_wr_data;
            if (w_finish) r_out_valid <= 1'b1;
            else if (i_m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_c_prev <= '0;
                r_c_cur  <= WIDTH'(1);
                if (w_value >= r_modulus) begin
                    // zero modulus and pair make both result fields zero
                    r_mod <= '0;
                    r_rp  <= '0;
                    r_rc  <= '0;
                end else begin
                    r_mod <= r_modulus;
                    r_rp  <= r_modulus;
                    r_rc  <= w_value;
                end
            end
            S_CHK: begin
                r_rem <= '0;
                r_dvd <= r_rp;
                r_acc <= '0;
                r_cnt <= CNT_W'(FIELD_W - 1);
            end
            S_DIV: begin
                r_rem <= w_ge ? FIELD_W'(w_trial - {1'b0, r_rc}) : w_trial[FIELD_W-1:0];
                r_dvd <= {r_dvd[FIELD_W-2:0], 1'b0};
                r_acc <= {r_acc[WIDTH-2:0], 1'b0} + (w_ge ? r_c_cur : '0);
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_UPD: begin
                r_rp     <= r_rc;
                r_rc     <= r_rem;
                r_c_prev <= r_c_cur;
                r_c_cur  <= r_c_prev - r_acc;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
        if (w_finish) begin
            r_out_inv <= w_inv;
            r_out_div <= r_rp;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - 2 * FIELD_W){1'b0}}, r_out_div, r_out_inv};

    `MIE_ASSERT_NXT(a_busy_after_xfer, i_clk, i_rst_n, w_in_xfer, r_state == S_CHK)
    `MIE_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_rc)
    `MIE_ASSERT_NXT(a_div_to_upd, i_clk, i_rst_n,
        (r_state == S_DIV) && (r_cnt == '0), r_state == S_UPD)
    `MIE_ASSERT_NXT(a_hold_when_full, i_clk, i_rst_n,
        (r_state == S_CHK) && (r_rc == '0) && r_out_valid && !i_m_axis_tready,
        (r_state == S_CHK) && r_out_valid)
    `MIE_ASSERT_NXT(a_upd_divisor_nz, i_clk, i_rst_n, r_state == S_UPD, r_rp != '0)

endmodule

`default_nettype wire

FILE: tb/modinv_checker.sv
// Checker for the modular inverse block: watches the config, input and result channels.
// Predicts each result by extended Euclid and compares; depends on modinv_pkg.
`timescale 1ns / 1ps

module modinv_checker
    import modinv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [FIELD_W-1:0]     i_cfg_wr_data,
    input  logic                   i_in_tvalid,
    input  logic                   i_in_tready,
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,   // [30:0] value
    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    input  logic [OUT_TDATA_W-1:0] i_out_tdata,  // [30:0] inverse, [61:31] divisor
    output int                     o_mismatches,
    output int                     o_outstanding
);

    // packed so that {divisor, inverse} lines up with tdata[61:0]
    typedef struct packed {
        logic [FIELD_W-1:0] divisor;
        logic [FIELD_W-1:0] inverse;
    } inv_result_t;

    inv_result_t        awaited_inverses[$];
    logic [FIELD_W-1:0] modulus_copy;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        modulus_copy  = MODULUS_RST;
    end

    // Bezout coefficients wrap at 32 bits, the datapath width
    function automatic inv_result_t predict_inverse(input logic [FIELD_W-1:0] m,
                                                    input logic [FIELD_W-1:0] a);
        logic [FIELD_W-1:0] r_prev, r_cur, quo, rem;
        logic [31:0]        c_prev, c_cur, c_next;
        logic [63:0]        lifted;
        inv_result_t        res;
        res = '0;
        if (a >= m) return res;
        r_prev = m;
        r_cur  = a;
        c_prev = '0;
        c_cur  = 32'd1;
        while (r_cur != '0) begin
            quo    = r_prev / r_cur;
            rem    = r_prev % r_cur;
            c_next = c_prev - 32'(quo * c_cur);
            r_prev = r_cur;
            r_cur  = rem;
            c_prev = c_cur;
            c_cur  = c_next;
        end
        // non-positive coefficient is lifted by the modulus
        if (c_prev[31] || c_prev == '0)
            lifted = {33'b0, m} + {{32{c_prev[31]}}, c_prev};
        else
            lifted = {32'b0, c_prev};
        res.inverse = lifted[FIELD_W-1:0];
        res.divisor = r_prev;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [FIELD_W-1:0] got_v,
                                 input logic [FIELD_W-1:0] want_v);
        $display("modinv mismatch at %0t: %s got %0d expected %0d", $realtime, what,
                 got_v, want_v);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        inv_result_t got, want;
        if (!i_rst_n) begin
            awaited_inverses.delete();
            modulus_copy = MODULUS_RST;
        end else begin
            // pop before push: a result never belongs to a value taken in the same cycle
            if (i_out_tvalid && i_out_tready) begin
                got = inv_result_t'(i_out_tdata[2*FIELD_W-1:0]);
                if (awaited_inverses.size() == 0) begin
                    flag_mismatch("result transfer with nothing expected", got.inverse, '0);
                end else begin
                    want = awaited_inverses.pop_front();
                    if (got.inverse !== want.inverse)
                        flag_mismatch("inverse", got.inverse, want.inverse);
                    if (got.divisor !== want.divisor)
                        flag_mismatch("divisor", got.divisor, want.divisor);
                end
            end
            if (i_in_tvalid && i_in_tready)
                awaited_inverses.push_back(predict_inverse(modulus_copy,
                                                           i_in_tdata[FIELD_W-1:0]));
            if (i_cfg_wr_en)
                modulus_copy = i_cfg_wr_data;
        end
        o_outstanding = awaited_inverses.size();
    end

endmodule

FILE: tb/testbench.sv
// Top of the modular inverse testbench: clock, reset, stimulus, receiver and verdict.
// Instantiates modular_inverse_ext_euclid and modinv_checker; depends on modinv_pkg.
`timescale 1ns / 1ps

module testbench;
    import modinv_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_wr_en;
    logic [FIELD_W-1:0]     cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [30:0] value, [31] zero pad
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [30:0] inverse, [61:31] divisor, [63:62] pad
    int                     mismatches;
    int                     outstanding;
    bit                     calm = 1'b0;
    bit                     hold_req = 1'b0;
    bit                     hold_done = 1'b0;

    modular_inverse_ext_euclid #(.WIDTH(32)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    modinv_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_tvalid   (s_tvalid),
        .i_in_tready   (s_tready),
        .i_in_tdata    (s_tdata),
        .i_out_tvalid  (m_tvalid),
        .i_out_tready  (m_tready),
        .i_out_tdata   (m_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // generous cap: several times the slowest legal run
    initial begin
        #36_000_000;
        $display("[modular_inverse_ext_euclid] ERROR");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request, none when calm
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (5000) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // leaves tvalid high on return so back-to-back values need no second assignment
    task automatic send_value(input logic [FIELD_W-1:0] v);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, v};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic set_modulus(input logic [FIELD_W-1:0] m);
        s_tvalid <= 1'b0;
        drain_results();
        repeat (3) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [FIELD_W-1:0] pick_value(input logic [FIELD_W-1:0] m);
        logic [FIELD_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = FIELD_W'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0:       v = '0;
                    1:       v = FIELD_W'(1);
                    2:       v = m - 1'b1;
                    default: v = m;
                endcase
            end
            default: v = FIELD_W'($urandom_range(0, 32'(m) - 1));
        endcase
        return v;
    endfunction

    initial begin : stimulus
        logic [FIELD_W-1:0] m;
        int                 count;
        i_rst_n     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // modulus from reset: zero, one, equal, above, all ones
        send_value(31'd0);
        send_value(31'd1);
        send_value(31'd2);
        send_value(31'd3);
        send_value(31'h7fffffff);

        // largest modulus, prime
        set_modulus(31'h7fffffff);
        send_value(31'd0);
        send_value(31'd1);
        send_value(31'h7ffffffe);
        send_value(31'h7fffffff);
        send_value(31'd2);
        send_value(31'd12345);
        send_value(31'h55555555);

        // consecutive Fibonacci pair: longest chain of Euclid rounds
        set_modulus(31'd1836311903);
        send_value(31'd1134903170);
        send_value(31'd1836311902);
        send_value(31'd0);

        // composite modulus: non-coprime values give gcd above one
        set_modulus(31'd1000);
        send_value(31'd500);
        send_value(31'd999);
        send_value(31'd3);
        send_value(31'd0);
        send_value(31'd1000);
        send_value(31'd1001);
        send_value(31'h2aaaaaaa);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0:       m = FIELD_W'($urandom_range(2, 300));
                1:       m = FIELD_W'($urandom_range(2, 32'h7fffffff));
                2:       m = (phase < 4) ? FIELD_W'(2) : 31'h7fffffff;
                default: m = FIELD_W'($urandom_range(301, 65535));
            endcase
            set_modulus(m);
            if (phase == 2) hold_req = 1'b1;
            if (phase == 7) calm = 1'b1;
            count = 50;
            for (int i = 0; i < count; i++) begin
                send_value(pick_value(m));
                if (!calm && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 7));
            end
        end
        s_tvalid <= 1'b0;

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("[modular_inverse_ext_euclid] OK");
        else
            $display("[modular_inverse_ext_euclid] ERROR");
        $finish;
    end

endmodule
